/* rtl/pfhp_pkg.sv */
package pfhp_pkg;

   localparam int VAL_W  = 16;
   localparam int CH_W   = 2;
   localparam int TOP_W  = 8;
   localparam int THR_W  = 2;
   localparam int SUM_W  = VAL_W + 3;
   localparam int STEP_W = VAL_W + 1;

   // threshold codes
   localparam logic [THR_W-1:0] THR_ALWAYS   = 2'd0;
   localparam logic [THR_W-1:0] THR_UNLOCKED = 2'd1;
   localparam logic [THR_W-1:0] THR_LOCKED   = 2'd2;

   localparam logic [STEP_W-1:0] STEP_UNLOCKED = STEP_W'(1 << (VAL_W - 10));
   localparam logic [STEP_W-1:0] STEP_LOCKED   = STEP_W'(1 << (VAL_W - 8));

   localparam logic [TOP_W:0] TAKEOVER_WINDOW = 9'd2;

   // command codes
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_LOCK   = 1'b1;

   // configuration register indexes
   localparam logic CSR_UNIT_MODE   = 1'b0;
   localparam logic CSR_SNAP_ENABLE = 1'b1;

   typedef enum logic [1:0] {
      MODE_TWIN   = 2'd0,
      MODE_SPLIT  = 2'd1,
      MODE_EDIT_A = 2'd2,
      MODE_EDIT_B = 2'd3
   } mode_type;

   typedef struct packed {
      logic             hit;
      logic [CH_W-1:0]  ch;
      logic [VAL_W-1:0] lp;
   } rpt_type;

   typedef struct packed {
      logic             pass;
      logic             to_unit_a;
      logic             to_unit_b;
      logic [CH_W-1:0]  param_index;
      logic [VAL_W-1:0] param_value;
   } res_type;

endpackage

/* rtl/pfhp_req_if.sv */
interface pfhp_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [1:0]  channel;
   logic [15:0] sample_value;

   modport source (output valid, cmd, channel, sample_value, input ready);
   modport sink (input valid, cmd, channel, sample_value, output ready);
endinterface

/* rtl/pfhp_rsp_if.sv */
interface pfhp_rsp_if;
   logic        valid;
   logic        ready;
   logic        to_unit_a;
   logic        to_unit_b;
   logic [1:0]  param_index;
   logic [15:0] param_value;

   modport source (output valid, to_unit_a, to_unit_b, param_index, param_value,
                   input ready);
   modport sink (input valid, to_unit_a, to_unit_b, param_index, param_value,
                 output ready);
endinterface

/* rtl/pfhp_csr_if.sv */
interface pfhp_csr_if;
   logic       valid;
   logic       ready;
   logic       addr;
   logic [1:0] data;

   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface

/* rtl/pfhp_filter.sv */
module pfhp_filter import pfhp_pkg::*; #(
   parameter int NUM_KNOBS = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  logic             cmd,
   input  logic [CH_W-1:0]  channel,
   input  logic [VAL_W-1:0] sample_value,
   output rpt_type          rpt
);

   localparam int KIDX_W = (NUM_KNOBS > 1) ? $clog2(NUM_KNOBS) : 1;

   logic [VAL_W-1:0] filt_ff [NUM_KNOBS];
   logic [VAL_W-1:0] rep_ff  [NUM_KNOBS];
   logic [THR_W-1:0] thr_ff  [NUM_KNOBS];

   logic [KIDX_W-1:0] kidx;
   logic              ch_ok;
   logic [SUM_W-1:0]  sum;
   logic [VAL_W-1:0]  lp;
   logic [VAL_W-1:0]  cur;
   logic [STEP_W-1:0] step;
   logic              up_hit;
   logic              dn_hit;

   assign kidx  = KIDX_W'(channel);
   assign ch_ok = (int'(channel) < NUM_KNOBS);

   // lp = (sample + 7*lp) >> 3
   assign sum = SUM_W'(sample_value) + SUM_W'({filt_ff[kidx], 3'b000})
              - SUM_W'(filt_ff[kidx]);
   assign lp  = sum[SUM_W-1:3];
   assign cur = rep_ff[kidx];

   always_comb begin
      case (thr_ff[kidx])
         THR_ALWAYS:   step = '0;
         THR_UNLOCKED: step = STEP_UNLOCKED;
         default:      step = STEP_LOCKED;
      endcase
   end

   assign up_hit = ({1'b0, lp} >= ({1'b0, cur} + step));
   assign dn_hit = ({1'b0, cur} >= step) && ({1'b0, lp} <= ({1'b0, cur} - step));

   always_comb begin
      rpt.hit = (cmd == CMD_SAMPLE) && ch_ok
              && ((thr_ff[kidx] == THR_ALWAYS) || up_hit || dn_hit);
      rpt.ch  = channel;
      rpt.lp  = lp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_KNOBS; i++) begin
            filt_ff[i] <= '0;
            rep_ff[i]  <= '0;
            thr_ff[i]  <= THR_ALWAYS;
         end
      end else if (fire) begin
         if (cmd == CMD_LOCK) begin
            for (int i = 0; i < NUM_KNOBS; i++) begin
               thr_ff[i] <= THR_LOCKED;
            end
         end else if (ch_ok) begin
            filt_ff[kidx] <= lp;
            if (rpt.hit) begin
               rep_ff[kidx] <= lp;
               thr_ff[kidx] <= THR_UNLOCKED;
            end
         end
      end
   end

endmodule

/* rtl/pfhp_route.sv */
module pfhp_route import pfhp_pkg::*; #(
   parameter int NUM_KNOBS = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     fire,
   input  logic     lock,
   input  rpt_type  rpt,
   input  mode_type unit_mode,
   input  logic     snap_enable,
   output res_type  res
);

   localparam int KIDX_W = (NUM_KNOBS > 1) ? $clog2(NUM_KNOBS) : 1;
   localparam int SIDX_W = $clog2(2 * NUM_KNOBS);

   logic [TOP_W-1:0] top_ff  [2*NUM_KNOBS];
   logic             snap_ff [NUM_KNOBS];

   logic [KIDX_W-1:0] kidx;
   logic [SIDX_W-1:0] sidx;
   logic [TOP_W-1:0]  top;
   logic [TOP_W:0]    diff;
   logic              single;
   logic              near;
   logic              pass;

   assign kidx   = KIDX_W'(rpt.ch);
   assign top    = rpt.lp[VAL_W-1:VAL_W-TOP_W];
   assign single = (unit_mode == MODE_EDIT_A) || (unit_mode == MODE_EDIT_B);
   // second unit's bytes sit one bank above the first
   assign sidx   = SIDX_W'(rpt.ch)
                 + ((unit_mode == MODE_EDIT_B) ? SIDX_W'(NUM_KNOBS) : SIDX_W'(0));

   always_comb begin
      if (top_ff[sidx] >= top) diff = {1'b0, top_ff[sidx] - top};
      else                     diff = {1'b0, top - top_ff[sidx]};
   end

   assign near = (diff <= TAKEOVER_WINDOW);
   assign pass = rpt.hit
              && (!single || !snap_enable || snap_ff[kidx] || near);

   always_comb begin
      res.pass        = pass;
      res.param_value = rpt.lp;
      case (unit_mode)
         MODE_TWIN: begin
            res.to_unit_a   = 1'b1;
            res.to_unit_b   = 1'b1;
            res.param_index = rpt.ch;
         end
         MODE_SPLIT: begin
            res.to_unit_a   = (rpt.ch < 2'd2);
            res.to_unit_b   = (rpt.ch >= 2'd2);
            res.param_index = (rpt.ch < 2'd2) ? rpt.ch : CH_W'(rpt.ch - 2'd2);
         end
         MODE_EDIT_A: begin
            res.to_unit_a   = 1'b1;
            res.to_unit_b   = 1'b0;
            res.param_index = rpt.ch;
         end
         default: begin
            res.to_unit_a   = 1'b0;
            res.to_unit_b   = 1'b1;
            res.param_index = rpt.ch;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2 * NUM_KNOBS; i++) begin
            top_ff[i] <= '0;
         end
         for (int i = 0; i < NUM_KNOBS; i++) begin
            snap_ff[i] <= 1'b0;
         end
      end else if (fire) begin
         if (lock) begin
            for (int i = 0; i < NUM_KNOBS; i++) begin
               snap_ff[i] <= 1'b0;
            end
         end else if (pass) begin
            // twin and split keep the first bank and leave snapping alone
            top_ff[sidx] <= top;
            if (single) begin
               snap_ff[kidx] <= 1'b1;
            end
         end
      end
   end

endmodule

/* rtl/pot_filter_hysteresis_pickup_top.sv */
// Knob front end for NUM_KNOBS channels: each sample word updates a one-pole
// filter, applies hysteresis against the last reported level, and routes the
// update by edit mode with optional soft takeover; a lock word raises every
// threshold and clears the snapped flags. One word is accepted per cycle while
// the input register is free or its word moves on. Each word passes through
// an input register, then the filter and routing logic that reads and updates
// the per-channel state, then the result register; only updates that pass are
// offered. Back-pressure on the result side stalls the input only while the
// result register is full. Configuration writes are always ready and take
// effect at once; change them only while the block is idle.
module pot_filter_hysteresis_pickup_top import pfhp_pkg::*; #(
   parameter int NUM_KNOBS = 4
) (
   input  logic       clock,
   input  logic       reset,
   pfhp_req_if.sink   req_bus,
   pfhp_rsp_if.source rsp_bus,
   pfhp_csr_if.sink   csr_bus
);

   logic             s1_vld_ff, s1_vld_in;
   logic             s1_cmd_ff;
   logic [CH_W-1:0]  s1_ch_ff;
   logic [VAL_W-1:0] s1_sample_ff;

   logic    out_vld_ff, out_vld_in;
   res_type out_ff;

   mode_type unit_mode_ff;
   logic     snap_enable_ff;

   logic    out_free;
   logic    fire;
   logic    in_take;
   rpt_type rpt;
   res_type res;

   assign out_free = !out_vld_ff || rsp_bus.ready;
   assign fire     = s1_vld_ff && out_free;
   assign req_bus.ready = !s1_vld_ff || out_free;
   assign in_take  = req_bus.valid && req_bus.ready;

   assign s1_vld_in  = req_bus.ready ? req_bus.valid : s1_vld_ff;
   assign out_vld_in = out_free ? (fire && res.pass) : out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         s1_cmd_ff    <= req_bus.cmd;
         s1_ch_ff     <= req_bus.channel;
         s1_sample_ff <= req_bus.sample_value;
      end
      if (fire) begin
         out_ff <= res;
      end
   end

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_mode_ff   <= MODE_TWIN;
         snap_enable_ff <= 1'b0;
      end else if (csr_bus.valid) begin
         case (csr_bus.addr)
            CSR_UNIT_MODE:   unit_mode_ff   <= mode_type'(csr_bus.data);
            CSR_SNAP_ENABLE: snap_enable_ff <= csr_bus.data[0];
            default:         ;
         endcase
      end
   end

   pfhp_filter #(
      .NUM_KNOBS (NUM_KNOBS)
   ) u_filter (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .cmd          (s1_cmd_ff),
      .channel      (s1_ch_ff),
      .sample_value (s1_sample_ff),
      .rpt          (rpt)
   );

   pfhp_route #(
      .NUM_KNOBS (NUM_KNOBS)
   ) u_route (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .lock        (s1_cmd_ff == CMD_LOCK),
      .rpt         (rpt),
      .unit_mode   (unit_mode_ff),
      .snap_enable (snap_enable_ff),
      .res         (res)
   );

   assign rsp_bus.valid       = out_vld_ff;
   assign rsp_bus.to_unit_a   = out_ff.to_unit_a;
   assign rsp_bus.to_unit_b   = out_ff.to_unit_b;
   assign rsp_bus.param_index = out_ff.param_index;
   assign rsp_bus.param_value = out_ff.param_value;

endmodule

/* rtl/pfhp_checker.sv */
module pfhp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_to_unit_a,
   input logic        rsp_to_unit_b,
   input logic [1:0]  rsp_param_index,
   input logic [15:0] rsp_param_value
);

   // a stalled result word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_param_value)
         && $stable(rsp_param_index) && $stable(rsp_to_unit_a)
         && $stable(rsp_to_unit_b))
      else $error("result word changed while stalled");

   // every update names at least one unit
   a_rsp_unit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_to_unit_a || rsp_to_unit_b))
      else $error("result word with no target unit");

   // a fresh result follows a word taken on the input
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result word without a matching input word");

endmodule

bind pot_filter_hysteresis_pickup_top pfhp_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_to_unit_a   (rsp_bus.to_unit_a),
   .rsp_to_unit_b   (rsp_bus.to_unit_b),
   .rsp_param_index (rsp_bus.param_index),
   .rsp_param_value (rsp_bus.param_value)
);
